// ===== rtl/wcw_pkg.sv =====
// wcw_pkg: shared types and constants for the weighted centroid window block.
// No dependencies; every rtl file except wcw_checker refers to it by scoped names.
`default_nettype none

package wcw_pkg;

    // fixed widths of the pixel channels and the accumulators
    localparam int CHAN_BITS      = 8;
    localparam int CHAN_SUM_BITS  = 10;    // three bytes summed
    localparam int PIX_MASS_BITS  = 8;     // per-pixel mass, 0..255
    localparam int MASS_BITS      = 32;    // total mass accumulator
    localparam int SUM_BITS       = 48;    // weighted coordinate accumulators

    // divide-by-3 of the channel sum: (s * 683) >> 11, exact for s <= 765
    localparam int DIV3_MULT      = 683;
    localparam int DIV3_SHIFT     = 11;
    localparam int DIV3_PROD_BITS = 20;

    // finished window sums handed from the accumulator to the divider
    typedef struct packed {
        logic [SUM_BITS-1:0]  col_sum;
        logic [SUM_BITS-1:0]  row_sum;
        logic [MASS_BITS-1:0] total;
    } wcw_sums_t;

    // divider sequencer
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_FINISH
    } wcw_state_t;

endpackage

`default_nettype wire

// ===== rtl/wcw_front.sv =====
// wcw_front: pixel mass, coordinate products and window accumulation.
// Depends on wcw_pkg; pushes finished window sums into wcw_queue.
`default_nettype none

module wcw_front #(
    parameter int COORD_BITS = 12
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic [wcw_pkg::CHAN_BITS-1:0]    blue,
    input  wire logic [wcw_pkg::CHAN_BITS-1:0]    green,
    input  wire logic [wcw_pkg::CHAN_BITS-1:0]    red,
    input  wire logic [COORD_BITS-1:0]            pixel_x,
    input  wire logic [COORD_BITS-1:0]            pixel_y,
    input  wire logic                             last_pixel,
    input  wire logic                             q_full,
    output logic                                  push,
    output wcw_pkg::wcw_sums_t                    push_data
);

    localparam int PROD_BITS = wcw_pkg::PIX_MASS_BITS + COORD_BITS;

    logic [wcw_pkg::CHAN_SUM_BITS-1:0]  chan_sum;
    logic [wcw_pkg::DIV3_PROD_BITS-1:0] mass_scaled;
    logic [wcw_pkg::PIX_MASS_BITS-1:0]  mass;
    logic                               advance;

    // stage 1: pixel mass
    logic                               s1_valid_reg;
    logic [wcw_pkg::PIX_MASS_BITS-1:0]  s1_mass_reg;
    logic [COORD_BITS-1:0]              s1_x_reg;
    logic [COORD_BITS-1:0]              s1_y_reg;
    logic                               s1_last_reg;

    // stage 2: weighted coordinates
    logic                               s2_valid_reg;
    logic [wcw_pkg::PIX_MASS_BITS-1:0]  s2_mass_reg;
    logic [PROD_BITS-1:0]               s2_px_reg;
    logic [PROD_BITS-1:0]               s2_py_reg;
    logic                               s2_last_reg;

    // accumulators
    logic [wcw_pkg::MASS_BITS-1:0]      mass_total_reg, mass_total_next;
    logic [wcw_pkg::SUM_BITS-1:0]       col_sum_reg, col_sum_next;
    logic [wcw_pkg::SUM_BITS-1:0]       row_sum_reg, row_sum_next;

    // only a closing pixel facing a full queue holds the pipe
    assign advance  = !(s2_valid_reg && s2_last_reg && q_full);
    assign in_ready = advance;

    assign chan_sum = wcw_pkg::CHAN_SUM_BITS'(blue) + wcw_pkg::CHAN_SUM_BITS'(green)
                    + wcw_pkg::CHAN_SUM_BITS'(red);
    assign mass_scaled = wcw_pkg::DIV3_PROD_BITS'(chan_sum)
                       * wcw_pkg::DIV3_PROD_BITS'(wcw_pkg::DIV3_MULT);
    assign mass = mass_scaled[wcw_pkg::DIV3_SHIFT +: wcw_pkg::PIX_MASS_BITS];

    always_comb
    begin
        mass_total_next = mass_total_reg + wcw_pkg::MASS_BITS'(s2_mass_reg);
        col_sum_next    = col_sum_reg + wcw_pkg::SUM_BITS'(s2_px_reg);
        row_sum_next    = row_sum_reg + wcw_pkg::SUM_BITS'(s2_py_reg);
    end

    assign push              = advance && s2_valid_reg && s2_last_reg;
    assign push_data.col_sum = col_sum_next;
    assign push_data.row_sum = row_sum_next;
    assign push_data.total   = mass_total_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            mass_total_reg <= '0;
            col_sum_reg    <= '0;
            row_sum_reg    <= '0;
        end
        else if (advance)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            if (s2_valid_reg)
            begin
                if (s2_last_reg)
                begin
                    mass_total_reg <= '0;
                    col_sum_reg    <= '0;
                    row_sum_reg    <= '0;
                end
                else
                begin
                    mass_total_reg <= mass_total_next;
                    col_sum_reg    <= col_sum_next;
                    row_sum_reg    <= row_sum_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_mass_reg <= mass;
            s1_x_reg    <= pixel_x;
            s1_y_reg    <= pixel_y;
            s1_last_reg <= last_pixel;
            s2_mass_reg <= s1_mass_reg;
            s2_px_reg   <= PROD_BITS'(s1_mass_reg) * PROD_BITS'(s1_x_reg);
            s2_py_reg   <= PROD_BITS'(s1_mass_reg) * PROD_BITS'(s1_y_reg);
            s2_last_reg <= s1_last_reg;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/wcw_queue.sv =====
// wcw_queue: two-entry queue of finished window sums.
// Depends on wcw_pkg; sits between wcw_front and wcw_divider.
`default_nettype none

module wcw_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire wcw_pkg::wcw_sums_t  push_data,
    output logic                     full,
    output logic                     q_valid,
    input  wire logic                pop,
    output wcw_pkg::wcw_sums_t       q_data
);

    wcw_pkg::wcw_sums_t entry_reg [2];
    logic               wr_ptr_reg;
    logic               rd_ptr_reg;
    logic [1:0]         count_reg, count_next;

    assign full    = (count_reg == 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_data  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

// ===== rtl/wcw_divider.sv =====
// wcw_divider: bit-serial division of both weighted sums by the total mass,
// saturation, and the result output register. Depends on wcw_pkg.
`default_nettype none

module wcw_divider #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 8
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              q_valid,
    input  wire wcw_pkg::wcw_sums_t                q_data,
    output logic                                   pop,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [COORD_BITS+FRAC_BITS-1:0]        center_x,
    output logic [COORD_BITS+FRAC_BITS-1:0]        center_y,
    output logic                                   empty_window
);

    localparam int OUT_BITS = COORD_BITS + FRAC_BITS;
    localparam int DW       = wcw_pkg::SUM_BITS + FRAC_BITS;
    localparam int CNT_BITS = $clog2(DW);
    localparam int REM_BITS = wcw_pkg::MASS_BITS + 1;

    wcw_pkg::wcw_state_t state_reg, state_next;

    logic                           do_step;
    logic                           load_out;
    logic [wcw_pkg::MASS_BITS-1:0]  div_reg;
    logic [REM_BITS-1:0]            remx_reg, remy_reg;
    logic [DW-1:0]                  dqx_reg, dqy_reg;
    logic [CNT_BITS-1:0]            cnt_reg;
    logic                           zero_reg;

    logic [REM_BITS-1:0]            trial_x, trial_y, divisor_ext;
    logic                           ge_x, ge_y;
    logic [OUT_BITS-1:0]            quot_x, quot_y;

    logic                           out_valid_reg;
    logic [OUT_BITS-1:0]            center_x_reg, center_y_reg;
    logic                           empty_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            wcw_pkg::ST_IDLE:
            begin
                if (q_valid)
                    state_next = (q_data.total == '0) ? wcw_pkg::ST_FINISH : wcw_pkg::ST_DIV;
            end
            wcw_pkg::ST_DIV:
            begin
                if (cnt_reg == '0)
                    state_next = wcw_pkg::ST_FINISH;
            end
            wcw_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = wcw_pkg::ST_IDLE;
            end
            default: state_next = wcw_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        pop      = 1'b0;
        do_step  = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            wcw_pkg::ST_IDLE:   pop      = q_valid;
            wcw_pkg::ST_DIV:    do_step  = 1'b1;
            wcw_pkg::ST_FINISH: load_out = !out_valid_reg || out_ready;
            default:            pop      = 1'b0;
        endcase
    end

    // one restoring step per lane, shared divisor
    assign divisor_ext = {1'b0, div_reg};
    assign trial_x     = {remx_reg[REM_BITS-2:0], dqx_reg[DW-1]};
    assign trial_y     = {remy_reg[REM_BITS-2:0], dqy_reg[DW-1]};
    assign ge_x        = (trial_x >= divisor_ext);
    assign ge_y        = (trial_y >= divisor_ext);

    // quotients beyond the output range clamp to all ones
    assign quot_x = (|dqx_reg[DW-1:OUT_BITS]) ? {OUT_BITS{1'b1}} : dqx_reg[OUT_BITS-1:0];
    assign quot_y = (|dqy_reg[DW-1:OUT_BITS]) ? {OUT_BITS{1'b1}} : dqy_reg[OUT_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wcw_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            div_reg  <= q_data.total;
            remx_reg <= '0;
            remy_reg <= '0;
            dqx_reg  <= DW'(q_data.col_sum) << FRAC_BITS;
            dqy_reg  <= DW'(q_data.row_sum) << FRAC_BITS;
            cnt_reg  <= CNT_BITS'(DW - 1);
            zero_reg <= (q_data.total == '0);
        end
        else if (do_step)
        begin
            remx_reg <= ge_x ? (trial_x - divisor_ext) : trial_x;
            remy_reg <= ge_y ? (trial_y - divisor_ext) : trial_y;
            dqx_reg  <= {dqx_reg[DW-2:0], ge_x};
            dqy_reg  <= {dqy_reg[DW-2:0], ge_y};
            cnt_reg  <= cnt_reg - CNT_BITS'(1);
        end
        if (load_out)
        begin
            center_x_reg <= zero_reg ? '0 : quot_x;
            center_y_reg <= zero_reg ? '0 : quot_y;
            empty_reg    <= zero_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign center_x     = center_x_reg;
    assign center_y     = center_y_reg;
    assign empty_window = empty_reg;

endmodule

`default_nettype wire

// ===== rtl/weighted_centroid_window.sv =====
// weighted_centroid_window: top level of the intensity-weighted centroid block.
// Depends on wcw_pkg, wcw_front, wcw_queue and wcw_divider.
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------------
//  pixel   | in_valid / in_ready  | blue, green, red, pixel_x, pixel_y, last_pixel
//  result  | out_valid/ out_ready | center_x, center_y, empty_window
//
// Pixels are taken one per clock while in_ready is high. The front pipe (mass,
// then coordinate products) feeds the accumulators through its stage registers.
// A closed window waits in a two-entry queue for the serial divider, which
// takes one window at a time: it pops the window in idle, divides one quotient
// bit per step for a nonzero window, then loads the result register; an empty
// window skips the division and goes straight to the load.
// in_ready drops only while a closing pixel meets a full queue.
// Reset (rst_n low, asynchronous) clears the sums, pipe, queue and sequencer.
`default_nettype none

module weighted_centroid_window #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 8
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // pixel transactions
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [wcw_pkg::CHAN_BITS-1:0]     blue,
    input  wire logic [wcw_pkg::CHAN_BITS-1:0]     green,
    input  wire logic [wcw_pkg::CHAN_BITS-1:0]     red,
    input  wire logic [COORD_BITS-1:0]             pixel_x,
    input  wire logic [COORD_BITS-1:0]             pixel_y,
    input  wire logic                              last_pixel,
    // result transactions
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [COORD_BITS+FRAC_BITS-1:0]        center_x,
    output logic [COORD_BITS+FRAC_BITS-1:0]        center_y,
    output logic                                   empty_window
);

    logic               push;
    logic               q_full;
    logic               q_valid;
    logic               pop;
    wcw_pkg::wcw_sums_t push_data;
    wcw_pkg::wcw_sums_t q_data;

    // front: per-pixel mass, weighted coordinates, window sums
    wcw_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .blue       (blue),
        .green      (green),
        .red        (red),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .last_pixel (last_pixel),
        .q_full     (q_full),
        .push       (push),
        .push_data  (push_data)
    );

    // closed windows waiting for the divider
    wcw_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .q_valid   (q_valid),
        .pop       (pop),
        .q_data    (q_data)
    );

    // back: centroid division and result register
    wcw_divider #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_divider (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_data       (q_data),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .center_x     (center_x),
        .center_y     (center_y),
        .empty_window (empty_window)
    );

endmodule

`default_nettype wire

// ===== rtl/wcw_checker.sv =====
// wcw_checker: port-level assertions for weighted_centroid_window, bound to it.
// Depends on nothing but the top level's ports.
`default_nettype none

module wcw_checker #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 8
) (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_valid,
    input wire logic                          in_ready,
    input wire logic                          last_pixel,
    input wire logic                          out_valid,
    input wire logic                          out_ready,
    input wire logic [COORD_BITS+FRAC_BITS-1:0] center_x,
    input wire logic [COORD_BITS+FRAC_BITS-1:0] center_y,
    input wire logic                          empty_window
);

    // windows closed at the input but not yet delivered
    logic [3:0] pending_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= 4'd0;
        else
            pending_reg <= pending_reg + 4'(in_valid && in_ready && last_pixel)
                         - 4'(out_valid && out_ready);
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result transaction dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(center_x) && $stable(center_y)
                                    && $stable(empty_window))
        else $error("result payload changed while stalled");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && empty_window |-> center_x == '0 && center_y == '0)
        else $error("empty window with nonzero centroid");

    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 4'd0)
        else $error("result without a closed window");

endmodule

bind weighted_centroid_window wcw_checker #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
) u_wcw_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .last_pixel   (last_pixel),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .center_x     (center_x),
    .center_y     (center_y),
    .empty_window (empty_window)
);

`default_nettype wire
